@@ design/krt_pkg.sv @@
// Package for the keyed record table: sizes, command and status codes,
// the record type and the control bundle broadcast along the cell row.
// No dependencies.
`default_nettype none

package krt_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int NAME_BYTES  = 8;

  localparam int KEY_W  = 32;
  localparam int NAME_W = 64;
  localparam int AMT_W  = 16;
  localparam int OP_W   = 3;
  localparam int ST_W   = 3;
  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

  // Bytes of the name word that are kept
  localparam logic [NAME_W-1:0] NAME_MASK =
    (NAME_BYTES >= 8) ? {NAME_W{1'b1}}
                      : ((NAME_W'(1) << (8 * NAME_BYTES)) - NAME_W'(1));

  // Command codes
  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd1;
  localparam logic [OP_W-1:0] OP_MODIFY = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
  localparam logic [OP_W-1:0] OP_LIST   = 3'd4;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [ST_W-1:0] ST_DUPLICATE = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd4;

  // Cell row commands
  localparam logic [1:0] CMD_HOLD  = 2'd0;
  localparam logic [1:0] CMD_SHIFT = 2'd1;
  localparam logic [1:0] CMD_SORT  = 2'd2;
  localparam logic [1:0] CMD_CLOSE = 2'd3;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [NAME_W-1:0]       name;
    logic [AMT_W-1:0]        amount;
  } rec_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic             parity;
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] gap;
  } cell_ctl_t;

endpackage

`default_nettype wire

@@ design/krt_cell.sv @@
// One cell of the record row: holds a single record and trades it with
// its neighbours under the broadcast row command. Depends on krt_pkg.
`default_nettype none

module krt_cell (
  input  wire logic               clk,
  input  wire krt_pkg::cell_ctl_t ctl,
  input  wire logic [krt_pkg::IDX_W-1:0] idx,
  input  wire krt_pkg::rec_t      right_rec,
  input  wire krt_pkg::rec_t      left_rec,
  input  wire logic               left_gt,
  output krt_pkg::rec_t           rec,
  output logic                    gt_right
);

  krt_pkg::rec_t rec_next;
  logic          lead;
  logic          pair_right_ok;
  logic          pair_left_ok;

  // Compare own key with the right neighbour's (signed)
  assign gt_right = $signed(rec.key) > $signed(right_rec.key);

  // Pair membership for the current odd/even sort round
  assign lead          = (idx[0] == ctl.parity);
  assign pair_right_ok = (krt_pkg::CNT_W'(idx) + krt_pkg::CNT_W'(1)) < ctl.count;
  assign pair_left_ok  = (idx != '0) && (krt_pkg::CNT_W'(idx) < ctl.count);

  // Select the next content of the cell
  always_comb begin
    rec_next = rec;
    unique case (ctl.cmd)
      krt_pkg::CMD_HOLD: begin
        rec_next = rec;
      end
      krt_pkg::CMD_SHIFT: begin
        rec_next = right_rec;
      end
      krt_pkg::CMD_SORT: begin
        if (lead) begin
          if (pair_right_ok && gt_right) rec_next = right_rec;
        end else begin
          if (pair_left_ok && left_gt) rec_next = left_rec;
        end
      end
      krt_pkg::CMD_CLOSE: begin
        if (idx >= ctl.gap) rec_next = right_rec;
      end
      default: begin
        rec_next = rec;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rec <= rec_next;
  end

endmodule

`default_nettype wire

@@ design/keyed_record_table_top.sv @@
// Keyed record table: a row of TABLE_DEPTH record cells plus the command sequencer.
// Keyed requests rotate the row once past cell 0; a hit on delete then closes the gap in
// the finish state. The result strobe is registered from the finish state.
// List sorts by odd/even swaps, then streams one result a cycle as the row rotates.
// An empty list skips the sort and answers from the finish state.
// Results cannot be stalled. Reset empties the table. Depends on krt_pkg and krt_cell.
`default_nettype none

module keyed_record_table_top (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [krt_pkg::OP_W-1:0]          op,
  input  wire logic signed [krt_pkg::KEY_W-1:0]  key,
  input  wire logic [krt_pkg::NAME_W-1:0]        name_word,
  input  wire logic [krt_pkg::AMT_W-1:0]         amount,
  output logic                                   strobe,
  output logic [krt_pkg::ST_W-1:0]               status,
  output logic signed [krt_pkg::KEY_W-1:0]       out_key,
  output logic [krt_pkg::NAME_W-1:0]             out_name,
  output logic [krt_pkg::AMT_W-1:0]              out_amount,
  output logic                                   last
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SORT   = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  localparam logic [krt_pkg::CNT_W-1:0] LAST_STEP = krt_pkg::CNT_W'(krt_pkg::TABLE_DEPTH - 1);
  localparam logic [krt_pkg::CNT_W-1:0] FULL_CNT  = krt_pkg::CNT_W'(krt_pkg::TABLE_DEPTH);

  logic [1:0]                     state;
  logic [krt_pkg::CNT_W-1:0]      step;
  logic [krt_pkg::CNT_W-1:0]      count;
  logic [krt_pkg::OP_W-1:0]       op_q;
  logic signed [krt_pkg::KEY_W-1:0] key_q;
  logic [krt_pkg::NAME_W-1:0]     name_q;
  logic [krt_pkg::AMT_W-1:0]      amount_q;
  logic                           found;
  logic [krt_pkg::IDX_W-1:0]      hit_idx;
  krt_pkg::rec_t                  found_rec;

  krt_pkg::rec_t                  recs [krt_pkg::TABLE_DEPTH];
  logic                           gts  [krt_pkg::TABLE_DEPTH];
  krt_pkg::rec_t                  head;
  krt_pkg::rec_t                  feed;
  krt_pkg::rec_t                  new_rec;
  krt_pkg::rec_t                  miss_rec;
  krt_pkg::cell_ctl_t             ctl;
  logic                           in_use;
  logic                           hit;
  logic                           full;

  logic                           emit_v;
  logic [krt_pkg::ST_W-1:0]       emit_status;
  krt_pkg::rec_t                  emit_rec;
  logic                           emit_last;

  assign busy = (state != S_IDLE);

  // Record leaving the row at cell 0, and its position in the table
  assign head     = recs[0];
  assign in_use   = (step < count);
  assign hit      = in_use && (head.key == key_q);
  assign full     = (count == FULL_CNT);
  assign new_rec  = '{key: key_q, name: name_q, amount: amount_q};
  assign miss_rec = '{key: key_q, name: '0, amount: '0};

  // Record written back at the tail of the rotating row
  always_comb begin
    feed = head;
    case (op_q)
      krt_pkg::OP_INSERT: begin
        if ((step == count) && !found && !full) feed = new_rec;
      end
      krt_pkg::OP_MODIFY: begin
        if (hit) feed = '{key: head.key, name: name_q, amount: amount_q};
      end
      default: begin
        feed = head;
      end
    endcase
  end

  // Broadcast row command
  always_comb begin
    ctl.parity = step[0];
    ctl.count  = count;
    ctl.gap    = hit_idx;
    ctl.cmd    = krt_pkg::CMD_HOLD;
    unique case (state)
      S_IDLE:   ctl.cmd = krt_pkg::CMD_HOLD;
      S_SORT:   ctl.cmd = krt_pkg::CMD_SORT;
      S_SCAN:   ctl.cmd = krt_pkg::CMD_SHIFT;
      S_FINISH: ctl.cmd = (op_q == krt_pkg::OP_DELETE && found) ? krt_pkg::CMD_CLOSE
                                                                 : krt_pkg::CMD_HOLD;
      default:  ctl.cmd = krt_pkg::CMD_HOLD;
    endcase
  end

  // Row of record cells
  for (genvar g = 0; g < krt_pkg::TABLE_DEPTH; g++) begin : g_cell
    krt_pkg::rec_t right_rec;
    krt_pkg::rec_t left_rec;
    logic          left_gt;

    if (g == krt_pkg::TABLE_DEPTH - 1) begin : g_tail
      assign right_rec = feed;
    end else begin : g_body
      assign right_rec = recs[g + 1];
    end

    if (g == 0) begin : g_first
      assign left_rec = recs[0];
      assign left_gt  = 1'b0;
    end else begin : g_rest
      assign left_rec = recs[g - 1];
      assign left_gt  = gts[g - 1];
    end

    krt_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .idx       (krt_pkg::IDX_W'(g)),
      .right_rec (right_rec),
      .left_rec  (left_rec),
      .left_gt   (left_gt),
      .rec       (recs[g]),
      .gt_right  (gts[g])
    );
  end

  // Result selection
  always_comb begin
    emit_v      = 1'b0;
    emit_status = krt_pkg::ST_OK;
    emit_rec    = head;
    emit_last   = 1'b1;
    if (state == S_SCAN && op_q == krt_pkg::OP_LIST && in_use) begin
      emit_v    = 1'b1;
      emit_last = (step == count - krt_pkg::CNT_W'(1));
    end else if (state == S_FINISH) begin
      case (op_q)
        krt_pkg::OP_INSERT: begin
          emit_v = 1'b1;
          if (found) begin
            emit_status = krt_pkg::ST_DUPLICATE;
            emit_rec    = miss_rec;
          end else if (full) begin
            emit_status = krt_pkg::ST_FULL;
            emit_rec    = miss_rec;
          end else begin
            emit_rec    = new_rec;
          end
        end
        krt_pkg::OP_SEARCH, krt_pkg::OP_MODIFY, krt_pkg::OP_DELETE: begin
          emit_v = 1'b1;
          if (found) begin
            emit_rec    = found_rec;
          end else begin
            emit_status = krt_pkg::ST_NOT_FOUND;
            emit_rec    = miss_rec;
          end
        end
        krt_pkg::OP_LIST: begin
          if (count == '0) begin
            emit_v      = 1'b1;
            emit_status = krt_pkg::ST_EMPTY;
            emit_rec    = '{key: '0, name: '0, amount: '0};
          end
        end
        default: begin
          emit_v = 1'b0;
        end
      endcase
    end
  end

  // Sequencer and entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      step   <= '0;
      count  <= '0;
      found  <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= emit_v;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            step  <= '0;
            found <= 1'b0;
            case (op)
              krt_pkg::OP_INSERT, krt_pkg::OP_SEARCH,
              krt_pkg::OP_MODIFY, krt_pkg::OP_DELETE: begin
                state <= S_SCAN;
              end
              krt_pkg::OP_LIST: begin
                state <= (count == '0) ? S_FINISH : S_SORT;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_SORT: begin
          if (step == LAST_STEP) begin
            step  <= '0;
            state <= S_SCAN;
          end else begin
            step <= step + krt_pkg::CNT_W'(1);
          end
        end
        S_SCAN: begin
          if (hit) found <= 1'b1;
          if (step == LAST_STEP) begin
            state <= S_FINISH;
          end else begin
            step <= step + krt_pkg::CNT_W'(1);
          end
        end
        S_FINISH: begin
          state <= S_IDLE;
          if (op_q == krt_pkg::OP_INSERT && !found && !full) begin
            count <= count + krt_pkg::CNT_W'(1);
          end else if (op_q == krt_pkg::OP_DELETE && found) begin
            count <= count - krt_pkg::CNT_W'(1);
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Hold the request fields and the record that was hit
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      op_q     <= op;
      key_q    <= key;
      name_q   <= name_word & krt_pkg::NAME_MASK;
      amount_q <= amount;
    end
    if (state == S_SCAN && hit) begin
      hit_idx   <= step[krt_pkg::IDX_W-1:0];
      found_rec <= feed;
    end
  end

  // Result payload registers
  always_ff @(posedge clk) begin
    if (emit_v) begin
      status     <= emit_status;
      out_key    <= emit_rec.key;
      out_name   <= emit_rec.name;
      out_amount <= emit_rec.amount;
      last       <= emit_last;
    end
  end

endmodule

`default_nettype wire

@@ dv/tb_keyed_record_table_top.sv @@
// Self-checking bench for keyed_record_table_top: drives insert, search, modify,
// delete and list requests and checks every result against a behavioural table.
// Depends on krt_pkg and the keyed_record_table_top RTL.

module tb_keyed_record_table_top;
  import krt_pkg::*;

  // Op codes the block ignores
  localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam logic signed [KEY_W-1:0] KEY_LO = 32'sh8000_0000;
  localparam logic signed [KEY_W-1:0] KEY_HI = 32'sh7FFF_FFFF;
  localparam logic [NAME_W-1:0] NAME_ONES = {NAME_W{1'b1}};
  localparam logic [AMT_W-1:0] AMT_ONES = {AMT_W{1'b1}};

  localparam int POOL_SIZE      = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 2 * TABLE_DEPTH + 20;

  typedef struct {
    logic [ST_W-1:0]         status;
    logic signed [KEY_W-1:0] key;
    logic [NAME_W-1:0]       name;
    logic [AMT_W-1:0]        amount;
    logic                    last;
  } reply_t;

  // Behavioural copy of the table plus the queue of replies still owed
  class record_board;
    rec_t        rows[TABLE_DEPTH];
    int          fill;
    reply_t      owed[$];
    int          errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function int entries();
      return fill;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    function logic signed [KEY_W-1:0] stored_key(int idx);
      return rows[idx].key;
    endfunction

    function int find_row(logic signed [KEY_W-1:0] k);
      int hit;
      hit = -1;
      for (int i = 0; i < fill; i++)
        if (rows[i].key == k) hit = i;
      return hit;
    endfunction

    function void owe(logic [ST_W-1:0] st, logic signed [KEY_W-1:0] k,
                      logic [NAME_W-1:0] nm, logic [AMT_W-1:0] am, logic fin);
      reply_t r;
      r.status = st;
      r.key    = k;
      r.name   = nm;
      r.amount = am;
      r.last   = fin;
      owed.push_back(r);
    endfunction

    // Apply one accepted request to the table and queue its replies
    function void note_request(logic [OP_W-1:0] c, logic signed [KEY_W-1:0] k,
                               logic [NAME_W-1:0] nm_in, logic [AMT_W-1:0] am);
      logic [NAME_W-1:0] nm;
      int   hit;
      int   j;
      rec_t tmp;
      nm  = nm_in & NAME_MASK;
      hit = find_row(k);
      case (c)
        OP_INSERT: begin
          if (hit >= 0) begin
            owe(ST_DUPLICATE, k, '0, '0, 1'b1);
          end else if (fill >= TABLE_DEPTH) begin
            owe(ST_FULL, k, '0, '0, 1'b1);
          end else begin
            rows[fill].key    = k;
            rows[fill].name   = nm;
            rows[fill].amount = am;
            fill++;
            owe(ST_OK, k, nm, am, 1'b1);
          end
        end
        OP_SEARCH, OP_MODIFY, OP_DELETE: begin
          if (hit < 0) begin
            owe(ST_NOT_FOUND, k, '0, '0, 1'b1);
          end else begin
            if (c == OP_MODIFY) begin
              rows[hit].name   = nm;
              rows[hit].amount = am;
            end
            owe(ST_OK, rows[hit].key, rows[hit].name, rows[hit].amount, 1'b1);
            // close the gap left by a removed record
            if (c == OP_DELETE) begin
              for (int i = hit; i + 1 < fill; i++) rows[i] = rows[i + 1];
              fill--;
            end
          end
        end
        OP_LIST: begin
          if (fill == 0) begin
            owe(ST_EMPTY, '0, '0, '0, 1'b1);
          end else begin
            // keys are unique, so any stable ascending sort gives the same order
            for (int i = 1; i < fill; i++) begin
              tmp = rows[i];
              j   = i;
              while (j > 0 && $signed(rows[j - 1].key) > $signed(tmp.key)) begin
                rows[j] = rows[j - 1];
                j--;
              end
              rows[j] = tmp;
            end
            for (int i = 0; i < fill; i++)
              owe(ST_OK, rows[i].key, rows[i].name, rows[i].amount, i + 1 == fill);
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one strobed result with the oldest reply owed
    function void check_result(logic [ST_W-1:0] st, logic signed [KEY_W-1:0] k,
                               logic [NAME_W-1:0] nm, logic [AMT_W-1:0] am,
                               logic fin);
      reply_t w;
      if (owed.size() == 0) begin
        $error("unexpected result: status %0d key %0d", st, k);
        errors++;
        return;
      end
      w = owed.pop_front();
      if (st !== w.status) begin
        $error("status: expected %0d, got %0d", w.status, st);
        errors++;
      end
      if (k !== w.key) begin
        $error("out_key: expected %0d, got %0d", w.key, k);
        errors++;
      end
      if (nm !== w.name) begin
        $error("out_name: expected %h, got %h", w.name, nm);
        errors++;
      end
      if (am !== w.amount) begin
        $error("out_amount: expected %0d, got %0d", w.amount, am);
        errors++;
      end
      if (fin !== w.last) begin
        $error("last: expected %0b, got %0b", w.last, fin);
        errors++;
      end
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic [OP_W-1:0]         op;
  logic signed [KEY_W-1:0] key;
  logic [NAME_W-1:0]       name_word;
  logic [AMT_W-1:0]        amount;
  logic                    strobe;
  logic [ST_W-1:0]         status;
  logic signed [KEY_W-1:0] out_key;
  logic [NAME_W-1:0]       out_name;
  logic [AMT_W-1:0]        out_amount;
  logic                    last;

  record_board             board;
  int                      idle_pct;
  int                      quiet_cycles;
  logic signed [KEY_W-1:0] key_pool[POOL_SIZE];

  keyed_record_table_top uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .op         (op),
    .key        (key),
    .name_word  (name_word),
    .amount     (amount),
    .strobe     (strobe),
    .status     (status),
    .out_key    (out_key),
    .out_name   (out_name),
    .out_amount (out_amount),
    .last       (last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Check each strobed result against the table
  always @(posedge clk) begin
    if (!rst && strobe) board.check_result(status, out_key, out_name, out_amount, last);
  end

  // Abort when nothing has moved for too long
  always @(posedge clk) begin
    if ((start && !busy) || strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Present one request, hold it until taken, then record it
  task automatic issue(input logic [OP_W-1:0] c, input logic signed [KEY_W-1:0] k,
                       input logic [NAME_W-1:0] nm, input logic [AMT_W-1:0] am);
    if (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    start     <= 1'b1;
    op        <= c;
    key       <= k;
    name_word <= nm;
    amount    <= am;
    do @(posedge clk); while (busy);
    board.note_request(c, k, nm, am);
  endtask

  // Random request, keys mostly from the pool or already stored
  task automatic mixed_command();
    int                      pick;
    int                      roll;
    logic [OP_W-1:0]         c;
    logic signed [KEY_W-1:0] k;
    pick = $urandom_range(0, 99);
    if (pick < 30) c = OP_INSERT;
    else if (pick < 48) c = OP_SEARCH;
    else if (pick < 63) c = OP_MODIFY;
    else if (pick < 85) c = OP_DELETE;
    else if (pick < 95) c = OP_LIST;
    else begin
      case ($urandom_range(0, 2))
        0: c = OP_SPARE_5;
        1: c = OP_SPARE_6;
        default: c = OP_SPARE_7;
      endcase
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
    else if (roll < 85 && board.entries() > 0)
      k = board.stored_key($urandom_range(0, board.entries() - 1));
    else k = $urandom;
    issue(c, k, {$urandom, $urandom}, AMT_W'($urandom));
  endtask

  initial begin
    logic signed [KEY_W-1:0] fill_key;
    board        = new();
    quiet_cycles = 0;
    idle_pct     = 40;
    rst          = 1'b1;
    start        = 1'b0;
    op           = OP_INSERT;
    key          = '0;
    name_word    = '0;
    amount       = '0;
    fill_key     = '0;
    key_pool[0]  = KEY_LO;
    key_pool[1]  = KEY_HI;
    key_pool[2]  = '0;
    key_pool[3]  = -1;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // empty table: list, and misses on search, modify and delete
    issue(OP_LIST, '0, '0, '0);
    issue(OP_SEARCH, 5, '0, '0);
    issue(OP_MODIFY, KEY_HI, NAME_ONES, AMT_ONES);
    issue(OP_DELETE, KEY_LO, '0, '0);
    // extremes of key, name and amount
    issue(OP_INSERT, KEY_HI, '0, '0);
    issue(OP_INSERT, KEY_LO, NAME_ONES, AMT_ONES);
    issue(OP_INSERT, 0, 64'h4847_4645_4443_4241, 16'd1);
    issue(OP_INSERT, -1, {$urandom, $urandom}, 16'h8000);
    issue(OP_INSERT, KEY_LO, {$urandom, $urandom}, 16'd7);
    issue(OP_SEARCH, KEY_LO, '0, '0);
    issue(OP_SEARCH, 0, NAME_ONES, AMT_ONES);
    issue(OP_MODIFY, -1, NAME_ONES, AMT_ONES);
    issue(OP_MODIFY, KEY_HI, {$urandom, $urandom}, 16'h00FF);
    issue(OP_LIST, '0, '0, '0);
    // ignored op codes
    issue(OP_SPARE_5, KEY_LO, NAME_ONES, AMT_ONES);
    issue(OP_SPARE_6, KEY_HI, '0, '0);
    issue(OP_SPARE_7, 0, NAME_ONES, '0);
    // remove from the middle and the end, then drain
    issue(OP_DELETE, 0, '0, '0);
    issue(OP_DELETE, KEY_HI, '0, '0);
    issue(OP_SEARCH, 0, '0, '0);
    issue(OP_LIST, '0, '0, '0);
    issue(OP_DELETE, KEY_LO, '0, '0);
    issue(OP_DELETE, -1, '0, '0);
    issue(OP_LIST, '0, '0, '0);

    // mixed traffic on a small key set
    idle_pct = 30;
    repeat (70) mixed_command();

    // fill the table back to back, then overflow it
    idle_pct = 0;
    while (board.entries() < TABLE_DEPTH) begin
      fill_key = $urandom;
      issue(OP_INSERT, fill_key, {$urandom, $urandom}, AMT_W'($urandom));
    end
    issue(OP_INSERT, $urandom, {$urandom, $urandom}, AMT_W'($urandom));
    issue(OP_INSERT, fill_key, {$urandom, $urandom}, AMT_W'($urandom));
    issue(OP_LIST, '0, '0, '0);
    issue(OP_DELETE, board.stored_key(0), '0, '0);
    issue(OP_INSERT, KEY_HI, NAME_ONES, AMT_ONES);
    issue(OP_INSERT, KEY_LO, NAME_ONES, AMT_ONES);
    issue(OP_SEARCH, KEY_HI, '0, '0);

    // mixed traffic on a full table, with idle bursts
    idle_pct = 35;
    repeat (45) mixed_command();

    // closing stretch with no idling
    idle_pct = 0;
    repeat (40) mixed_command();
    start <= 1'b0;

    // drain outstanding replies and watch for strays
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (board.errors == 0 && board.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/krt_pkg.sv
design/krt_cell.sv
design/keyed_record_table_top.sv
dv/tb_keyed_record_table_top.sv
